### sv/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// Round cone support point: shared package
// Widths, register indexes, sphere codes and reset values used by all files.
// ----------------------------------------------------------------------------
package rcsp_pkg;

	// Default coordinate width (Q8.8 at 16 bits).
	localparam int COORD_WIDTH_DEF = 16;

	// Configuration register indexes.
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_BACK  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_FRONT = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_LENGTH  = 2'd2;

	// Register reset values (1.0, 1.0 and 2.0 in Q8.8).
	localparam int RADIUS_BACK_RST  = 256;
	localparam int RADIUS_FRONT_RST = 256;
	localparam int AXIS_LENGTH_RST  = 512;

	// Sphere codes.
	localparam int CODE_WIDTH = 2;
	localparam logic [CODE_WIDTH-1:0] SPHERE_BACK     = 2'd0;
	localparam logic [CODE_WIDTH-1:0] SPHERE_FRONT    = 2'd1;
	localparam logic [CODE_WIDTH-1:0] SPHERE_ENCLOSED = 2'd2;

	// Unit direction is Q2.14; its magnitude never exceeds 1.0.
	localparam int DIR_FRAC   = 14;
	localparam int DIR_WIDTH  = 16;
	localparam int QUOT_BITS  = 15;
	// The squared norm is scaled by 2^16 before the root, giving a Q8.16 norm.
	localparam int NORM_SHIFT = 16;
	localparam int NORM_EXTRA = 8;
	// Numerator scale of the normalizing divide.
	localparam int DIV_SHIFT  = 22;

endpackage

### sv/rcsp_square.sv
// ----------------------------------------------------------------------------
// Round cone support point: squared norm
// Two stages: three squares, then their sum.
// ----------------------------------------------------------------------------
module rcsp_square #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] in_v [3],
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2*COORD_WIDTH+1:0]      out_sum,
	output logic signed [COORD_WIDTH-1:0] out_v [3]
);
	localparam int SQW  = 2 * COORD_WIDTH;
	localparam int SUMW = 2 * COORD_WIDTH + 2;

	logic                          vld_s1, vld_s2;
	logic                          en_s1, en_s2;
	logic [SQW-1:0]                sq_s1 [3];
	logic signed [COORD_WIDTH-1:0] v_s1 [3];
	logic signed [COORD_WIDTH-1:0] v_s2 [3];
	logic [SUMW-1:0]               sum_s2;
	logic [COORD_WIDTH-1:0]        mag [3];

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_v[i][COORD_WIDTH-1] ? COORD_WIDTH'(-in_v[i]) : COORD_WIDTH'(in_v[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQW'(mag[i]) * SQW'(mag[i]);
				v_s1[i]  <= in_v[i];
			end
		end
		if (en_s2) begin
			sum_s2 <= SUMW'(sq_s1[0]) + SUMW'(sq_s1[1]) + SUMW'(sq_s1[2]);
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= v_s1[i];
			end
		end
	end

	assign out_valid = vld_s2;
	assign out_sum   = sum_s2;
	assign out_v     = v_s2;

endmodule

### sv/rcsp_sqrt.sv
// ----------------------------------------------------------------------------
// Round cone support point: pipelined square root
// One root bit per stage, restoring method, with a side payload carried along.
// ----------------------------------------------------------------------------
module rcsp_sqrt #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF,
	parameter int SIDE_WIDTH  = 3 * rcsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [2*COORD_WIDTH+1:0]                 in_sum,
	input  logic [SIDE_WIDTH-1:0]                    in_side,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [COORD_WIDTH+rcsp_pkg::NORM_EXTRA-1:0] out_root,
	output logic [SIDE_WIDTH-1:0]                    out_side
);
	import rcsp_pkg::*;

	localparam int SUMW = 2 * COORD_WIDTH + 2;
	localparam int RW   = SUMW + NORM_SHIFT;
	localparam int NW   = COORD_WIDTH + NORM_EXTRA;
	localparam int NS   = NW + 1;

	logic [NS-1:0]         vld;
	logic [NS:0]           en;
	logic [RW-1:0]         rem_s  [NS];
	logic [NW-1:0]         root_s [NS];
	logic [SIDE_WIDTH-1:0] side_s [NS];

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= {in_sum, NORM_SHIFT'(0)};
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		localparam int B = NW - k;
		logic [RW-1:0] trial;
		logic          take;

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
		assign trial = (RW'(root_s[k-1]) << (B + 1)) + (RW'(1) << (2 * B));
		assign take  = rem_s[k-1] >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= take ? rem_s[k-1] - trial : rem_s[k-1];
				root_s[k] <= take ? (root_s[k-1] | (NW'(1) << B)) : root_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

### sv/rcsp_div.sv
// ----------------------------------------------------------------------------
// Round cone support point: pipelined normalizing divider
// Three lanes share the norm; one quotient bit per stage, rounded half away.
// ----------------------------------------------------------------------------
module rcsp_div #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [COORD_WIDTH+rcsp_pkg::NORM_EXTRA-1:0] in_norm,
	input  logic signed [COORD_WIDTH-1:0]               in_v [3],
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [rcsp_pkg::DIR_WIDTH-1:0]       out_d [3]
);
	import rcsp_pkg::*;

	localparam int NW = COORD_WIDTH + NORM_EXTRA;
	localparam int DW = COORD_WIDTH + DIV_SHIFT;
	localparam int NS = QUOT_BITS + 1;

	logic [NS-1:0]        vld;
	logic [NS:0]          en;
	logic [DW-1:0]        rem_s  [NS][3];
	logic [QUOT_BITS-1:0] q_s    [NS][3];
	logic [2:0]           neg_s  [NS];
	logic                 zero_s [NS];
	logic [NW-1:0]        norm_s [NS];
	logic [COORD_WIDTH-1:0] mag [3];

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_v[i][COORD_WIDTH-1] ? COORD_WIDTH'(-in_v[i]) : COORD_WIDTH'(in_v[i]);
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) begin
				vld[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// Entry stage: magnitude scaled by 2^22 plus half the divisor for rounding.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (DW'(mag[i]) << DIV_SHIFT) + DW'(in_norm >> 1);
				q_s[0][i]   <= '0;
				neg_s[0][i] <= in_v[i][COORD_WIDTH-1];
			end
			zero_s[0] <= (in_norm == '0);
			norm_s[0] <= in_norm;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		localparam int B = QUOT_BITS - k;
		logic [DW-1:0] sub;

		assign sub = DW'(norm_s[k-1]) << B;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_s[k-1][i] >= sub) begin
						rem_s[k][i] <= rem_s[k-1][i] - sub;
						q_s[k][i]   <= q_s[k-1][i] | (QUOT_BITS'(1) << B);
					end else begin
						rem_s[k][i] <= rem_s[k-1][i];
						q_s[k][i]   <= q_s[k-1][i];
					end
				end
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
				norm_s[k] <= norm_s[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zero_s[NS-1]) begin
				out_d[i] = '0;
			end else if (neg_s[NS-1][i]) begin
				out_d[i] = -$signed(DIR_WIDTH'(q_s[NS-1][i]));
			end else begin
				out_d[i] = $signed(DIR_WIDTH'(q_s[NS-1][i]));
			end
		end
	end

	assign out_valid = vld[NS-1];

endmodule

### sv/rcsp_point.sv
// ----------------------------------------------------------------------------
// Round cone support point: sphere choice and point
// Side test, radius select, scaling by the radius and offset along z.
// ----------------------------------------------------------------------------
module rcsp_point #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [rcsp_pkg::DIR_WIDTH-1:0] in_d [3],
	input  logic [COORD_WIDTH-1:0]                radius_back,
	input  logic [COORD_WIDTH-1:0]                radius_front,
	input  logic [COORD_WIDTH-1:0]                axis_length,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [COORD_WIDTH+1:0]         out_p [3],
	output logic [rcsp_pkg::CODE_WIDTH-1:0]       out_code
);
	import rcsp_pkg::*;

	localparam int PW = DIR_WIDTH + COORD_WIDTH + 1;
	localparam int ZW = PW + 1;
	localparam int OW = COORD_WIDTH + 2;
	localparam logic [ZW-1:0] HALF = ZW'(1) << (DIR_FRAC - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [COORD_WIDTH:0]   diff;
	logic [COORD_WIDTH:0]          diff_mag;
	logic signed [ZW-1:0]          lhs;
	logic                          front;

	logic signed [DIR_WIDTH-1:0]   d_s1 [3];
	logic signed [PW-1:0]          slope_s1;
	logic                          encl_s1, lt_s1;

	logic signed [DIR_WIDTH-1:0]   d_s2 [3];
	logic [COORD_WIDTH-1:0]        r_s2;
	logic                          front_s2;
	logic [CODE_WIDTH-1:0]         code_s2;

	logic signed [PW-1:0]          p_s3 [3];
	logic signed [ZW-1:0]          off_s3;
	logic [CODE_WIDTH-1:0]         code_s3;

	logic signed [OW-1:0]          p_s4 [3];
	logic [CODE_WIDTH-1:0]         code_s4;

	logic signed [ZW-1:0]          tot [3];
	logic [ZW-1:0]                 tmag [3];
	logic [ZW-1:0]                 qmag [3];
	logic signed [ZW-1:0]          res [3];

	assign en_s4    = !vld_s4 || out_ready;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	assign diff     = $signed({1'b0, radius_back}) - $signed({1'b0, radius_front});
	assign diff_mag = diff[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-diff) : (COORD_WIDTH + 1)'(diff);
	assign lhs      = ZW'(diff) <<< DIR_FRAC;
	assign front    = encl_s1 ? lt_s1 : (lhs < ZW'(slope_s1));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot[i]  = (i == 2) ? ZW'(p_s3[i]) + off_s3 : ZW'(p_s3[i]);
			tmag[i] = tot[i][ZW-1] ? ZW'(-tot[i]) : ZW'(tot[i]);
			qmag[i] = (tmag[i] + HALF) >> DIR_FRAC;
			res[i]  = tot[i][ZW-1] ? -$signed(qmag[i]) : $signed(qmag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1     <= in_d;
			slope_s1 <= PW'(in_d[2]) * PW'($signed({1'b0, axis_length}));
			encl_s1  <= diff_mag >= (COORD_WIDTH + 1)'(axis_length);
			lt_s1    <= radius_back < radius_front;
		end
		if (en_s2) begin
			d_s2     <= d_s1;
			r_s2     <= front ? radius_front : radius_back;
			front_s2 <= front;
			if (encl_s1) begin
				code_s2 <= SPHERE_ENCLOSED;
			end else begin
				code_s2 <= front ? SPHERE_FRONT : SPHERE_BACK;
			end
		end
		if (en_s3) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= PW'(d_s2[i]) * PW'($signed({1'b0, r_s2}));
			end
			off_s3  <= front_s2 ? (ZW'(axis_length) << (DIR_FRAC - 1))
			                    : -(ZW'(axis_length) << (DIR_FRAC - 1));
			code_s3 <= code_s2;
		end
		if (en_s4) begin
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= OW'(res[i]);
			end
			code_s4 <= code_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_p     = p_s4;
	assign out_code  = code_s4;

endmodule

### sv/round_cone_support_point_unit.sv
// ----------------------------------------------------------------------------
// Round cone support point unit
// Support mapping of a round cone (two spheres on z joined by a tangent cone).
// ----------------------------------------------------------------------------
// The unit takes one direction word per cycle while the output is not
// stalled and returns, in order, one support point word per direction. The
// squared norm has a square and a sum stage, the square root an entry stage
// and a stage per root bit, the normalizing divider an entry stage and a
// stage per quotient bit, and the point section a slope, a radius select, a
// scaling and a rounding stage. The square root and the divider set the depth;
// every stage holds one word, so the sustained rate is one word per cycle.
// Each stage moves forward when it is empty or when the stage after it moves,
// so bubbles close up and a stall on the output holds every word in place.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// and must only change while no word is in flight. A zero direction gives the
// center of the chosen sphere; when one sphere encloses the other the larger
// one is used and sphere_code reports the enclosed case.
// ----------------------------------------------------------------------------
module round_cone_support_point_unit #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [rcsp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]                  cfg_wdata,
	input  logic                                    dir_valid,
	output logic                                    dir_ready,
	input  logic signed [COORD_WIDTH-1:0]           dir_x,
	input  logic signed [COORD_WIDTH-1:0]           dir_y,
	input  logic signed [COORD_WIDTH-1:0]           dir_z,
	output logic                                    point_valid,
	input  logic                                    point_ready,
	output logic signed [COORD_WIDTH+1:0]           point_x,
	output logic signed [COORD_WIDTH+1:0]           point_y,
	output logic signed [COORD_WIDTH+1:0]           point_z,
	output logic [rcsp_pkg::CODE_WIDTH-1:0]         sphere_code
);
	import rcsp_pkg::*;

	localparam int NW = COORD_WIDTH + NORM_EXTRA;
	localparam int SW = 3 * COORD_WIDTH;

	// Configuration registers.
	logic [COORD_WIDTH-1:0] radius_back_q, radius_front_q, axis_length_q;

	// Stage handshakes between the pipeline sections.
	logic                          sq_valid, sq_ready;
	logic [2*COORD_WIDTH+1:0]      sq_sum;
	logic signed [COORD_WIDTH-1:0] sq_v [3];
	logic                          rt_valid, rt_ready;
	logic [NW-1:0]                 rt_norm;
	logic [SW-1:0]                 rt_side;
	logic signed [COORD_WIDTH-1:0] rt_v [3];
	logic                          dv_valid, dv_ready;
	logic signed [DIR_WIDTH-1:0]   dv_d [3];
	logic signed [COORD_WIDTH-1:0] in_v [3];
	logic signed [COORD_WIDTH+1:0] pt_p [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_back_q  <= COORD_WIDTH'(RADIUS_BACK_RST);
			radius_front_q <= COORD_WIDTH'(RADIUS_FRONT_RST);
			axis_length_q  <= COORD_WIDTH'(AXIS_LENGTH_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS_BACK:  radius_back_q  <= cfg_wdata;
				REG_RADIUS_FRONT: radius_front_q <= cfg_wdata;
				REG_AXIS_LENGTH:  axis_length_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_v[0] = dir_x;
	assign in_v[1] = dir_y;
	assign in_v[2] = dir_z;

	// Squared length of the raw direction.
	rcsp_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dir_valid),
		.in_ready  (dir_ready),
		.in_v      (in_v),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_sum   (sq_sum),
		.out_v     (sq_v)
	);

	// Norm in Q8.16; the raw components ride along as side data.
	rcsp_sqrt #(.COORD_WIDTH(COORD_WIDTH), .SIDE_WIDTH(SW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_sum    (sq_sum),
		.in_side   ({sq_v[0], sq_v[1], sq_v[2]}),
		.out_valid (rt_valid),
		.out_ready (rt_ready),
		.out_root  (rt_norm),
		.out_side  (rt_side)
	);

	assign rt_v[0] = $signed(rt_side[3*COORD_WIDTH-1:2*COORD_WIDTH]);
	assign rt_v[1] = $signed(rt_side[2*COORD_WIDTH-1:COORD_WIDTH]);
	assign rt_v[2] = $signed(rt_side[COORD_WIDTH-1:0]);

	// Unit direction in Q2.14.
	rcsp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_ready  (rt_ready),
		.in_norm   (rt_norm),
		.in_v      (rt_v),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_d     (dv_d)
	);

	// Sphere choice and the support point; its last stage is the output register.
	rcsp_point #(.COORD_WIDTH(COORD_WIDTH)) u_point (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (dv_valid),
		.in_ready     (dv_ready),
		.in_d         (dv_d),
		.radius_back  (radius_back_q),
		.radius_front (radius_front_q),
		.axis_length  (axis_length_q),
		.out_valid    (point_valid),
		.out_ready    (point_ready),
		.out_p        (pt_p),
		.out_code     (sphere_code)
	);

	assign point_x = pt_p[0];
	assign point_y = pt_p[1];
	assign point_z = pt_p[2];

endmodule

### sv/rcsp_checker.sv
// ----------------------------------------------------------------------------
// Round cone support point: port checker
// Concurrent checks on the top level ports, bound to the unit.
// ----------------------------------------------------------------------------
module rcsp_checker #(
	parameter int COORD_WIDTH = rcsp_pkg::COORD_WIDTH_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_we,
	input logic [rcsp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [COORD_WIDTH-1:0]               cfg_wdata,
	input logic                                 dir_valid,
	input logic                                 dir_ready,
	input logic signed [COORD_WIDTH-1:0]        dir_x,
	input logic signed [COORD_WIDTH-1:0]        dir_y,
	input logic signed [COORD_WIDTH-1:0]        dir_z,
	input logic                                 point_valid,
	input logic                                 point_ready,
	input logic signed [COORD_WIDTH+1:0]        point_x,
	input logic signed [COORD_WIDTH+1:0]        point_y,
	input logic signed [COORD_WIDTH+1:0]        point_z,
	input logic [rcsp_pkg::CODE_WIDTH-1:0]      sphere_code
);
	import rcsp_pkg::*;

	// A stalled result word keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid && $stable(point_x)
			&& $stable(point_y) && $stable(point_z) && $stable(sphere_code))
		else $error("result word changed while stalled");

	// Only the three defined sphere codes ever leave the unit.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> sphere_code == SPHERE_BACK || sphere_code == SPHERE_FRONT
			|| sphere_code == SPHERE_ENCLOSED)
		else $error("undefined sphere code");

	// The input is only refused when the whole pipeline is full and stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_ready |-> point_valid && !point_ready)
		else $error("input refused without an output stall");

	// No result word right after reset.
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !point_valid)
		else $error("result word present after reset");

endmodule

bind round_cone_support_point_unit rcsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rcsp_checker (.*);
